// File: rtl/msched_pkg.sv
// Shared constants and types of the multi-timer deadline scheduler.
// Used by msched_pick, the top level and the testbench; depends on nothing.
package msched_pkg;

   localparam int SLOTS     = 16;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int ID_W      = 4;
   localparam int TIME_W    = 32;
   localparam int DELAY_W   = 31;
   localparam int MEM_W     = DELAY_W + TIME_W;
   localparam int MAX_OUT   = 16;
   localparam int LIST_W    = $clog2(MAX_OUT);
   localparam int NFIRE_W   = $clog2(MAX_OUT + 1);
   localparam int CNT_W     = $clog2(SLOTS + 1);

   localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
   localparam logic [TIME_W-1:0]  TIME_SIGN = {1'b1, {(TIME_W-1){1'b0}}};

   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // Control from the sequencer to the deadline comparator.
   typedef struct packed {
      logic              clr;
      logic              vld;
      logic              armed;
      logic              picked;
      logic              pick_en;
      logic [SLOT_W-1:0] idx;
   } pick_ctl_type;

   // Outcome of one pass over the timer memory.
   typedef struct packed {
      logic               due_fnd;
      logic [SLOT_W-1:0]  due_idx;
      logic [DELAY_W-1:0] due_per;
      logic               st_idle;
      logic [DELAY_W-1:0] st_delay;
   } pick_res_type;

endpackage

// File: rtl/msched_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module msched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/msched_pick.sv
// Deadline comparator: follows the entries read from the timer memory during
// one pass and keeps the earliest due candidate and the earliest armed timer.
// Depends on msched_pkg.
module msched_pick (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [msched_pkg::TIME_W-1:0] now,
   input  msched_pkg::pick_ctl_type     ctl,
   input  logic [msched_pkg::MEM_W-1:0] rd_data,
   output msched_pkg::pick_res_type     res
);
   import msched_pkg::*;

   logic [TIME_W-1:0]  dl;
   logic [DELAY_W-1:0] per;
   logic [TIME_W-1:0]  diff;
   logic [TIME_W-1:0]  key;
   logic               due;
   logic               take_due;
   logic               take_arm;
   logic [TIME_W-1:0]  sdiff;
   logic               sdue;

   logic               due_fnd_ff, due_fnd_in;
   logic [TIME_W-1:0]  due_key_ff, due_key_in;
   logic [SLOT_W-1:0]  due_idx_ff, due_idx_in;
   logic [DELAY_W-1:0] due_per_ff, due_per_in;
   logic               arm_fnd_ff, arm_fnd_in;
   logic [TIME_W-1:0]  arm_key_ff, arm_key_in;

   always_comb begin
      dl   = rd_data[TIME_W-1:0];
      per  = rd_data[MEM_W-1:TIME_W];
      diff = dl - now;
      // Flipping the sign bit makes unsigned order follow the signed distance.
      key  = diff ^ TIME_SIGN;
      due  = (diff == '0) || diff[TIME_W-1];

      take_due = ctl.vld && ctl.pick_en && ctl.armed && !ctl.picked && due &&
                 (!due_fnd_ff || (key < due_key_ff));
      take_arm = ctl.vld && ctl.armed && (!arm_fnd_ff || (key < arm_key_ff));

      due_fnd_in = due_fnd_ff;
      due_key_in = due_key_ff;
      due_idx_in = due_idx_ff;
      due_per_in = due_per_ff;
      arm_fnd_in = arm_fnd_ff;
      arm_key_in = arm_key_ff;

      if (ctl.clr) begin
         due_fnd_in = 1'b0;
         arm_fnd_in = 1'b0;
      end else begin
         if (take_due) begin
            due_fnd_in = 1'b1;
            due_key_in = key;
            due_idx_in = ctl.idx;
            due_per_in = per;
         end
         if (take_arm) begin
            arm_fnd_in = 1'b1;
            arm_key_in = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         due_fnd_ff <= 1'b0;
         arm_fnd_ff <= 1'b0;
      end else begin
         due_fnd_ff <= due_fnd_in;
         arm_fnd_ff <= arm_fnd_in;
      end
      due_key_ff <= due_key_in;
      due_idx_ff <= due_idx_in;
      due_per_ff <= due_per_in;
      arm_key_ff <= arm_key_in;
   end

   always_comb begin
      sdiff = arm_key_ff ^ TIME_SIGN;
      sdue  = (sdiff == '0) || sdiff[TIME_W-1];

      res.due_fnd = due_fnd_ff;
      res.due_idx = due_idx_ff;
      res.due_per = due_per_ff;
      res.st_idle = !arm_fnd_ff;
      if (!arm_fnd_ff || sdue) begin
         res.st_delay = '0;
      end else if (sdiff > TIME_W'(DELAY_MAX)) begin
         res.st_delay = DELAY_MAX;
      end else begin
         res.st_delay = sdiff[DELAY_W-1:0];
      end
   end

endmodule

// File: rtl/multi_timer_deadline_scheduler_unit.sv
// Top level of the multi-timer deadline scheduler: sequencer, armed flags,
// fired list and result registers. Depends on msched_pkg, msched_ram, msched_pick.
//
//   channel   ports                                             direction
//   request   start, busy, req_op, req_slot_id, req_delay_ms,   in (busy out)
//             req_periodic
//   response  rsp_strobe, rsp_fired, rsp_fired_slot, rsp_last,  out
//             rsp_next_delay, rsp_idle
//
// Deadlines and periods live in one memory that is read one slot a cycle.
// Each pass over the slots picks at most one expiring timer.
// A start or cancel makes one pass before its result; a tick that fires
// k > 0 timers makes k + 1 passes, and its results come last.
// Results of one item come in back-to-back cycles; busy falls with the last.
// Synchronous reset disarms all timers and clears the millisecond counter.
module multi_timer_deadline_scheduler_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_op,
   input  logic [msched_pkg::ID_W-1:0]     req_slot_id,
   input  logic [msched_pkg::DELAY_W-1:0]  req_delay_ms,
   input  logic                            req_periodic,
   output logic                            rsp_strobe,
   output logic                            rsp_fired,
   output logic [msched_pkg::ID_W-1:0]     rsp_fired_slot,
   output logic                            rsp_last,
   output logic [msched_pkg::DELAY_W-1:0]  rsp_next_delay,
   output logic                            rsp_idle
);
   import msched_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [SLOTS-1:0]   armed_ff, armed_in;
   logic [SLOTS-1:0]   per_flag_ff, per_flag_in;
   logic [SLOTS-1:0]   picked_ff, picked_in;
   logic               tick_ff, tick_in;
   logic [NFIRE_W-1:0] nfire_ff, nfire_in;
   logic [NFIRE_W-1:0] ecnt_ff, ecnt_in;
   logic [SLOT_W-1:0]  list_ff [MAX_OUT];
   logic [SLOT_W-1:0]  list_in [MAX_OUT];
   logic               rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]  rd_idx_ff, rd_idx_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_fired_ff, rsp_fired_in;
   logic [ID_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [DELAY_W-1:0] rsp_delay_ff, rsp_delay_in;
   logic               rsp_idle_ff, rsp_idle_in;

   logic               accept;
   logic               slot_ok;
   logic [SLOT_W-1:0]  req_idx;
   logic               emit_last;

   logic               mem_we;
   logic [SLOT_W-1:0]  mem_waddr;
   logic [MEM_W-1:0]   mem_wdata;
   logic [MEM_W-1:0]   mem_rdata;

   pick_ctl_type       pick_ctl;
   pick_res_type       pick_res;

   msched_ram #(
      .WIDTH (MEM_W),
      .DEPTH (SLOTS)
   ) u_timer_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (cnt_ff[SLOT_W-1:0]),
      .rd_data (mem_rdata)
   );

   msched_pick u_pick (
      .clock   (clock),
      .reset   (reset),
      .now     (now_ff),
      .ctl     (pick_ctl),
      .rd_data (mem_rdata),
      .res     (pick_res)
   );

   assign accept  = start && (state_ff == S_IDLE);
   assign slot_ok = (32'(req_slot_id) < 32'(SLOTS));
   assign req_idx = SLOT_W'(req_slot_id);
   assign emit_last = (nfire_ff == '0) || ((ecnt_ff + 1'b1) == nfire_ff);

   always_comb begin
      pick_ctl.clr     = accept || ((state_ff == S_DECIDE) && pick_res.due_fnd);
      pick_ctl.vld     = rd_vld_ff;
      pick_ctl.armed   = armed_ff[rd_idx_ff];
      pick_ctl.picked  = picked_ff[rd_idx_ff];
      pick_ctl.pick_en = tick_ff && (nfire_ff < NFIRE_W'(MAX_OUT));
      pick_ctl.idx     = rd_idx_ff;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      now_in      = now_ff;
      armed_in    = armed_ff;
      per_flag_in = per_flag_ff;
      picked_in   = picked_ff;
      tick_in     = tick_ff;
      nfire_in    = nfire_ff;
      ecnt_in     = ecnt_ff;
      list_in     = list_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;

      rsp_strobe_in = 1'b0;
      rsp_fired_in  = rsp_fired_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_delay_in  = rsp_delay_ff;
      rsp_idle_in   = rsp_idle_ff;

      mem_we    = 1'b0;
      mem_waddr = req_idx;
      mem_wdata = {req_delay_ms, now_ff + TIME_W'(req_delay_ms)};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               tick_in   = (req_op == OP_TICK);
               picked_in = '0;
               nfire_in  = '0;
               cnt_in    = '0;
               state_in  = S_SCAN;
               case (req_op)
                  OP_START: begin
                     if (slot_ok) begin
                        mem_we               = 1'b1;
                        armed_in[req_idx]    = 1'b1;
                        per_flag_in[req_idx] = req_periodic;
                     end
                  end
                  OP_CANCEL: begin
                     if (slot_ok) begin
                        armed_in[req_idx] = 1'b0;
                     end
                  end
                  OP_TICK: begin
                     now_in = now_ff + 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Read data is registered, so the last entry is compared while the
            // counter holds SLOTS.
            if (cnt_ff == CNT_W'(SLOTS)) begin
               state_in = S_DECIDE;
            end else begin
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[SLOT_W-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            if (pick_res.due_fnd) begin
               picked_in[pick_res.due_idx]          = 1'b1;
               list_in[nfire_ff[LIST_W-1:0]]        = pick_res.due_idx;
               nfire_in                             = nfire_ff + 1'b1;
               if (per_flag_ff[pick_res.due_idx]) begin
                  mem_we    = 1'b1;
                  mem_waddr = pick_res.due_idx;
                  mem_wdata = {pick_res.due_per, now_ff + TIME_W'(pick_res.due_per)};
               end else begin
                  armed_in[pick_res.due_idx] = 1'b0;
               end
               cnt_in   = '0;
               state_in = S_SCAN;
            end else begin
               // The last pass saw the final timer state: its status holds.
               ecnt_in  = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_fired_in  = (nfire_ff != '0);
            rsp_slot_in   = (nfire_ff != '0) ? ID_W'(list_ff[ecnt_ff[LIST_W-1:0]]) : '0;
            rsp_last_in   = emit_last;
            rsp_delay_in  = pick_res.st_delay;
            rsp_idle_in   = pick_res.st_idle;
            if (emit_last) begin
               state_in = S_IDLE;
            end else begin
               ecnt_in = ecnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         now_ff        <= '0;
         armed_ff      <= '0;
         per_flag_ff   <= '0;
         picked_ff     <= '0;
         tick_ff       <= 1'b0;
         nfire_ff      <= '0;
         ecnt_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         now_ff        <= now_in;
         armed_ff      <= armed_in;
         per_flag_ff   <= per_flag_in;
         picked_ff     <= picked_in;
         tick_ff       <= tick_in;
         nfire_ff      <= nfire_in;
         ecnt_ff       <= ecnt_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      list_ff      <= list_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_delay_ff <= rsp_delay_in;
      rsp_idle_ff  <= rsp_idle_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_fired_slot = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_next_delay = rsp_delay_ff;
   assign rsp_idle       = rsp_idle_ff;

   a_idle_no_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_idle |-> (rsp_next_delay == '0))
      else $error("idle result reports a nonzero delay");

   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && rsp_fired)
      else $error("results of one item are not back to back");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_fired |-> rsp_last && (rsp_fired_slot == '0))
      else $error("status result is not a single final result");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted item did not start processing");

endmodule

// File: test/multi_timer_deadline_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-timer deadline scheduler.
// Needs msched_pkg and the multi_timer_deadline_scheduler_unit RTL.
module multi_timer_deadline_scheduler_unit_tb;
   import msched_pkg::*;

   localparam logic [1:0] OP_UNKNOWN   = 2'd3;
   localparam int         RANDOM_ITEMS = 85;
   localparam int         PAUSE_AT     = 55;
   localparam int         CALM_FIRST   = 40;
   localparam int         CALM_LAST    = 75;
   localparam int         SETTLE       = 2 * SLOTS + 8;
   localparam int         PLAN_ROWS    = 25;

   typedef struct packed {
      logic               fired;
      logic [ID_W-1:0]    slot;
      logic               last;
      logic [DELAY_W-1:0] next_delay;
      logic               idle;
   } timer_event_type;

   // A row with typed set carries its own answer: one status result.
   typedef struct packed {
      logic [1:0]         op;
      logic [ID_W-1:0]    slot;
      logic [DELAY_W-1:0] delay;
      logic               periodic;
      logic               typed;
      logic [DELAY_W-1:0] want_delay;
      logic               want_idle;
   } plan_row_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               busy;
   logic [1:0]         req_op         = OP_START;
   logic [ID_W-1:0]    req_slot_id    = '0;
   logic [DELAY_W-1:0] req_delay_ms   = '0;
   logic               req_periodic   = 1'b0;
   logic               rsp_strobe;
   logic               rsp_fired;
   logic [ID_W-1:0]    rsp_fired_slot;
   logic               rsp_last;
   logic [DELAY_W-1:0] rsp_next_delay;
   logic               rsp_idle;

   // Timer state as the block should hold it.
   logic [TIME_W-1:0]  now_ms;
   logic [TIME_W-1:0]  deadline [SLOTS];
   logic [DELAY_W-1:0] period [SLOTS];
   bit                 repeating [SLOTS];
   bit                 armed [SLOTS];

   timer_event_type    expected_events [$];
   timer_event_type    oldest_event;
   int                 mismatch_count = 0;

   // The burst rows arm every slot, one row each: odd slots with zero delay become
   // overdue on the tick and must fire ahead of the even ones.
   plan_row_type plan [PLAN_ROWS] = '{
      '{OP_TICK,    4'd0,  31'd0,     1'b0, 1'b1, 31'd0,     1'b1},
      '{OP_UNKNOWN, 4'd5,  DELAY_MAX, 1'b1, 1'b1, 31'd0,     1'b1},
      '{OP_CANCEL,  4'd3,  31'd0,     1'b0, 1'b1, 31'd0,     1'b1},
      '{OP_START,   4'd15, DELAY_MAX, 1'b0, 1'b1, DELAY_MAX, 1'b0},
      '{OP_CANCEL,  4'd15, DELAY_MAX, 1'b1, 1'b1, 31'd0,     1'b1},
      '{OP_START,   4'd0,  31'd0,     1'b1, 1'b1, 31'd0,     1'b0},
      '{OP_TICK,    4'd9,  31'd77,    1'b1, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd0,  31'd1,     1'b1, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd1,  31'd0,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd2,  31'd1,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd3,  31'd0,     1'b1, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd4,  31'd1,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd5,  31'd0,     1'b1, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd6,  31'd1,     1'b1, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd7,  31'd0,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd8,  31'd1,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd9,  31'd0,     1'b1, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd10, 31'd1,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd11, 31'd0,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd12, 31'd1,     1'b1, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd13, 31'd0,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd14, 31'd1,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_START,   4'd15, 31'd0,     1'b1, 1'b0, 31'd0,     1'b0},
      '{OP_TICK,    4'd0,  31'd0,     1'b0, 1'b0, 31'd0,     1'b0},
      '{OP_TICK,    4'd15, DELAY_MAX, 1'b0, 1'b0, 31'd0,     1'b0}
   };

   multi_timer_deadline_scheduler_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_slot_id    (req_slot_id),
      .req_delay_ms   (req_delay_ms),
      .req_periodic   (req_periodic),
      .rsp_strobe     (rsp_strobe),
      .rsp_fired      (rsp_fired),
      .rsp_fired_slot (rsp_fired_slot),
      .rsp_last       (rsp_last),
      .rsp_next_delay (rsp_next_delay),
      .rsp_idle       (rsp_idle)
   );

   always #5 clock = ~clock;

   function automatic logic [TIME_W-1:0] slot_gap(input int s);
      return deadline[s] - now_ms;
   endfunction

   function automatic bit slot_due(input int s);
      logic [TIME_W-1:0] gap;
      gap = slot_gap(s);
      return gap == '0 || gap[TIME_W-1];
   endfunction

   // Applies one item to the timer state and queues the results it causes.
   function automatic int advance_timers(input logic [1:0] op, input logic [ID_W-1:0] slot,
                                         input logic [DELAY_W-1:0] dly, input logic per);
      int                 fired_list [MAX_OUT];
      bit                 picked [SLOTS];
      int                 nfire;
      int                 best;
      int                 n;
      logic [TIME_W-1:0]  best_key;
      logic [TIME_W-1:0]  best_gap;
      logic               none_armed;
      logic [DELAY_W-1:0] wait_ms;
      timer_event_type    ev;
      nfire = 0;
      case (op)
         OP_START: begin
            deadline[slot]  = now_ms + TIME_W'(dly);
            period[slot]    = dly;
            repeating[slot] = per;
            armed[slot]     = 1'b1;
         end
         OP_CANCEL: armed[slot] = 1'b0;
         OP_TICK: begin
            now_ms = now_ms + 1'b1;
            for (int s = 0; s < SLOTS; s++) picked[s] = 1'b0;
            best = 0;
            while (nfire < MAX_OUT && best >= 0) begin
               best = -1;
               best_key = '0;
               for (int s = 0; s < SLOTS; s++) begin
                  if (armed[s] && !picked[s] && slot_due(s) &&
                      (best < 0 || (slot_gap(s) ^ TIME_SIGN) < best_key)) begin
                     best = s;
                     best_key = slot_gap(s) ^ TIME_SIGN;
                  end
               end
               if (best >= 0) begin
                  picked[best] = 1'b1;
                  fired_list[nfire] = best;
                  nfire++;
               end
            end
            for (int k = 0; k < nfire; k++) begin
               if (repeating[fired_list[k]])
                  deadline[fired_list[k]] = now_ms + TIME_W'(period[fired_list[k]]);
               else
                  armed[fired_list[k]] = 1'b0;
            end
         end
         default: ;  // an unknown op leaves the timers alone
      endcase

      best = -1;
      best_key = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (armed[s] && (best < 0 || (slot_gap(s) ^ TIME_SIGN) < best_key)) begin
            best = s;
            best_key = slot_gap(s) ^ TIME_SIGN;
         end
      end
      none_armed = (best < 0);
      // A gap that is not due has its sign bit clear, so it always fits the port.
      if (none_armed || slot_due(best)) begin
         wait_ms = '0;
      end else begin
         best_gap = slot_gap(best);
         wait_ms  = best_gap[DELAY_W-1:0];
      end

      n = (nfire > 0) ? nfire : 1;
      for (int k = 0; k < n; k++) begin
         ev.fired      = (nfire > 0);
         ev.slot       = (nfire > 0) ? ID_W'(fired_list[k]) : '0;
         ev.last       = (k == n - 1);
         ev.next_delay = wait_ms;
         ev.idle       = none_armed;
         expected_events.push_back(ev);
      end
      return n;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
   endtask

   // Holds the item on the request ports until the block takes it.
   task automatic present_item(input logic [1:0] op, input logic [ID_W-1:0] slot,
                               input logic [DELAY_W-1:0] dly, input logic per,
                               input logic typed, input timer_event_type answer);
      int n;
      req_op       <= op;
      req_slot_id  <= slot;
      req_delay_ms <= dly;
      req_periodic <= per;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      n = advance_timers(op, slot, dly, per);
      if (typed) begin
         repeat (n) void'(expected_events.pop_back());
         expected_events.push_back(answer);
      end
   endtask

   task automatic sender_gap(input bit allowed);
      if (allowed && $urandom_range(99) < 17) begin
         start <= 1'b0;
         repeat ($urandom_range(1, SETTLE)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_events.size() == 0) begin
            note_mismatch($sformatf("unexpected result: fired %0d slot %0d last %0d",
                                    rsp_fired, rsp_fired_slot, rsp_last));
         end else begin
            oldest_event = expected_events.pop_front();
            if (rsp_fired !== oldest_event.fired || rsp_fired_slot !== oldest_event.slot ||
                rsp_last !== oldest_event.last ||
                rsp_next_delay !== oldest_event.next_delay ||
                rsp_idle !== oldest_event.idle)
               note_mismatch($sformatf(
                  {"result mismatch: expected fired %0d slot %0d last %0d delay %0d ",
                   "idle %0d, got fired %0d slot %0d last %0d delay %0d idle %0d"},
                  oldest_event.fired, oldest_event.slot, oldest_event.last,
                  oldest_event.next_delay, oldest_event.idle, rsp_fired, rsp_fired_slot,
                  rsp_last, rsp_next_delay, rsp_idle));
         end
      end
   end

   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      timer_event_type    answer;
      logic [1:0]         op;
      logic [DELAY_W-1:0] dly;
      int                 pick;
      now_ms = '0;
      for (int s = 0; s < SLOTS; s++) begin
         deadline[s]  = '0;
         period[s]    = '0;
         repeating[s] = 1'b0;
         armed[s]     = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         sender_gap(1'b1);
         answer = '{1'b0, '0, 1'b1, plan[i].want_delay, plan[i].want_idle};
         present_item(plan[i].op, plan[i].slot, plan[i].delay, plan[i].periodic,
                      plan[i].typed, answer);
      end

      // Short delays dominate so that timers keep firing; a few far deadlines
      // and the ignored fields of cancel and tick exercise the upper bits.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == PAUSE_AT) begin
            start <= 1'b0;
            do @(posedge clock); while (expected_events.size() != 0);
         end else begin
            sender_gap(i < CALM_FIRST || i > CALM_LAST);
         end
         pick = $urandom_range(99);
         if (pick < 38)      op = OP_START;
         else if (pick < 52) op = OP_CANCEL;
         else if (pick < 95) op = OP_TICK;
         else                op = OP_UNKNOWN;
         pick = $urandom_range(9);
         if (pick < 7)       dly = DELAY_W'($urandom_range(0, 8));
         else if (pick == 7) dly = DELAY_W'($urandom);
         else if (pick == 8) dly = DELAY_MAX;
         else                dly = DELAY_W'($urandom_range(0, 64));
         present_item(op, ID_W'($urandom_range(0, SLOTS - 1)), dly,
                      1'($urandom_range(1)), 1'b0, '0);
      end

      start <= 1'b0;
      do @(posedge clock); while (expected_events.size() != 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/msched_pkg.sv
rtl/msched_ram.sv
rtl/msched_pick.sv
rtl/multi_timer_deadline_scheduler_unit.sv
test/multi_timer_deadline_scheduler_unit_tb.sv
